FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check, also active in reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/pdlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdlt_pkg;

  typedef enum logic [1:0] {
    REQ_TOCK   = 2'd0,
    REQ_PACKET = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_UNLOCKED = 2'd0,
    MODE_LOCKING  = 2'd1,
    MODE_LOCKED   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ALPHA      = 2'd0,
    CFG_LOCK_THR   = 2'd1,
    CFG_UNLOCK_THR = 2'd2,
    CFG_MAX_CORR   = 2'd3
  } cfg_idx_e;

  localparam logic [3:0]  AlphaReset      = 4'd4;
  localparam logic [19:0] AlphaMin        = 20'd1;
  localparam logic [19:0] AlphaMax        = 20'd8;
  localparam logic [19:0] LockThrReset    = 20'd50;
  localparam logic [19:0] UnlockThrReset  = 20'd500;
  localparam logic [19:0] MaxCorrReset    = 20'd200;
  localparam logic [3:0]  DriftExtraShift = 4'd2;
  localparam logic [3:0]  LockCountLimit  = 4'd10;
  localparam logic [3:0]  RelockCount     = 4'd5;
  localparam logic [3:0]  GoodCountMax    = 4'd15;

  typedef struct packed {
    logic [3:0]  alpha;
    logic [19:0] lock_thr;
    logic [19:0] unlock_thr;
    logic [19:0] max_corr;
  } cfg_t;

  typedef struct packed {
    logic               clear;
    logic signed [31:0] offset;
  } cmd_t;

  typedef struct packed {
    logic signed [20:0] correction;
    logic [1:0]         lock_status;
    logic signed [31:0] phase_average;
    logic signed [31:0] drift_average;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/pdlt_front.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdlt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        time_stamp_i,
  input  logic signed [31:0] offset_sample_i,
  input  logic               push_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  output pdlt_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  pdlt_pkg::req_e kind;
  pdlt_pkg::cmd_t cmd_new;
  pdlt_pkg::cmd_t mem_q [2];
  logic [31:0]    tock_q;
  logic [31:0]    raw;
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           accept, enq, deq;

  assign kind   = pdlt_pkg::req_e'(req_type_i);
  assign full_o = (cnt_q == 2'd2);
  assign accept = push_i && !full_o;
  assign enq    = accept && (kind != pdlt_pkg::REQ_TOCK);
  assign deq    = cmd_pop_i && (cnt_q != 2'd0);

  // packet offset wraps at 32 bits
  assign raw = (kind == pdlt_pkg::REQ_PACKET) ? (tock_q - time_stamp_i)
                                              : offset_sample_i;

  always_comb begin
    cmd_new.clear  = (kind == pdlt_pkg::REQ_CLEAR);
    cmd_new.offset = $signed(raw);
  end

  always_comb begin
    unique case ({enq, deq})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tock_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept && (kind == pdlt_pkg::REQ_TOCK)) begin
        tock_q <= time_stamp_i;
      end
      if (enq) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  `ASSERT_CLK(tock_store_a, (accept && (kind == pdlt_pkg::REQ_TOCK)) |=> (tock_q == $past(time_stamp_i)), "tock time not stored")
  `ASSERT_CLK(cnt_step_a, (enq && !deq) |=> (cnt_q == $past(cnt_q) + 2'd1), "queue count slip")

endmodule

`default_nettype wire

FILE: sv/pdlt_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdlt_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pdlt_pkg::result_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pdlt_pkg::result_t data_o
);

  pdlt_pkg::result_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;

  always_comb begin
    unique case ({wr, rd})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rd_ptr_q];

  // a result offered to a full queue is held until there is room
  `ASSERT_CLK(held_a, (push_i && full_o) |=> (push_i && $stable(data_i)), "result dropped")

endmodule

`default_nettype wire

FILE: sv/pdlt_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdlt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdlt_pkg::cfg_t    cfg_i,
  input  logic              cmd_valid_i,
  input  pdlt_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              res_valid_o,
  output pdlt_pkg::result_t res_o,
  input  logic              res_full_i
);

  typedef struct packed {
    logic               clear;
    logic signed [31:0] offset;
    logic signed [31:0] phase;
  } s1_t;

  typedef struct packed {
    logic signed [31:0] phase;
    logic signed [31:0] drift;
    pdlt_pkg::mode_e    mode;
  } s2_t;

  logic               en;
  logic               s1_valid_q, s2_valid_q;
  s1_t                s1_q;
  s2_t                s2_q;
  logic signed [31:0] phase_acc_q, drift_acc_q;
  pdlt_pkg::mode_e    mode_q, mode_d;
  logic [3:0]         gc_q, gc_d, gc_inc;

  logic signed [41:0] ph_sum, ph_shr;
  logic signed [31:0] phase_new;
  logic [3:0]         dshift;
  logic signed [32:0] diff;
  logic signed [44:0] dr_sum, dr_shr;
  logic signed [31:0] drift_new;
  logic [31:0]        neg_off;
  logic [30:0]        mag;
  logic               below_lock, below_unlock, above_unlock;
  logic signed [33:0] corr, lim, corr_cl, corr_adj, corr_fin;

  assign en        = !(s2_valid_q && res_full_i);
  assign cmd_pop_o = en && cmd_valid_i;

  // phase average
  always_comb begin
    ph_sum    = (42'(phase_acc_q) <<< cfg_i.alpha) - 42'(phase_acc_q) + 42'(cmd_i.offset);
    ph_shr    = ph_sum >>> cfg_i.alpha;
    phase_new = ph_shr[31:0];
  end

  // drift average, saturating
  always_comb begin
    dshift = cfg_i.alpha + pdlt_pkg::DriftExtraShift;
    diff   = 33'(s1_q.offset) - 33'(s1_q.phase);
    dr_sum = (45'(drift_acc_q) <<< dshift) - 45'(drift_acc_q) + 45'(diff);
    dr_shr = dr_sum >>> dshift;
    if ((&dr_shr[44:31]) || !(|dr_shr[44:31])) begin
      drift_new = dr_shr[31:0];
    end else if (dr_shr[44]) begin
      drift_new = 32'sh8000_0000;
    end else begin
      drift_new = 32'sh7fff_ffff;
    end
  end

  // offset magnitude, saturating at the top
  always_comb begin
    neg_off = -s1_q.offset;
    if (!s1_q.offset[31]) begin
      mag = s1_q.offset[30:0];
    end else if (neg_off[31]) begin
      mag = 31'h7fff_ffff;
    end else begin
      mag = neg_off[30:0];
    end
    below_lock   = (mag < 31'(cfg_i.lock_thr));
    below_unlock = (mag < 31'(cfg_i.unlock_thr));
    above_unlock = (mag > 31'(cfg_i.unlock_thr));
    gc_inc       = (gc_q != pdlt_pkg::GoodCountMax) ? gc_q + 4'd1 : gc_q;
  end

  // lock state machine: next state
  always_comb begin
    mode_d = mode_q;
    gc_d   = gc_q;
    unique case (mode_q)
      pdlt_pkg::MODE_LOCKING: begin
        if (below_lock) begin
          gc_d = gc_inc;
          if (gc_inc > pdlt_pkg::LockCountLimit) begin
            mode_d = pdlt_pkg::MODE_LOCKED;
          end
        end else if (above_unlock) begin
          mode_d = pdlt_pkg::MODE_UNLOCKED;
          gc_d   = 4'd0;
        end
      end
      pdlt_pkg::MODE_LOCKED: begin
        if (above_unlock) begin
          mode_d = pdlt_pkg::MODE_LOCKING;
          gc_d   = pdlt_pkg::RelockCount;
        end
      end
      default: begin
        if (below_unlock) begin
          mode_d = pdlt_pkg::MODE_LOCKING;
          gc_d   = 4'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      phase_acc_q <= '0;
      drift_acc_q <= '0;
      mode_q      <= pdlt_pkg::MODE_UNLOCKED;
      gc_q        <= 4'd0;
    end else if (en) begin
      s1_valid_q <= cmd_valid_i;
      s2_valid_q <= s1_valid_q && !s1_q.clear;
      if (cmd_valid_i) begin
        phase_acc_q <= cmd_i.clear ? 32'sd0 : phase_new;
      end
      if (s1_valid_q) begin
        if (s1_q.clear) begin
          drift_acc_q <= '0;
          mode_q      <= pdlt_pkg::MODE_UNLOCKED;
          gc_q        <= 4'd0;
        end else begin
          drift_acc_q <= drift_new;
          mode_q      <= mode_d;
          gc_q        <= gc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.clear  <= cmd_i.clear;
      s1_q.offset <= cmd_i.offset;
      s1_q.phase  <= phase_new;
      s2_q.phase  <= s1_q.phase;
      s2_q.drift  <= drift_new;
      s2_q.mode   <= mode_d;
    end
  end

  // lock state machine: outputs, and the correction
  always_comb begin
    corr    = -34'(s2_q.phase) - 34'(s2_q.drift);
    lim     = $signed({14'd0, cfg_i.max_corr});
    corr_cl = corr;
    if (corr_cl < -lim) begin
      corr_cl = -lim;
    end
    if (corr_cl > lim) begin
      corr_cl = lim;
    end
    corr_adj = corr_cl + $signed({33'd0, corr_cl[33]});
    corr_fin = (s2_q.mode == pdlt_pkg::MODE_LOCKED) ? (corr_adj >>> 1) : corr_cl;
    res_o.correction    = corr_fin[20:0];
    res_o.lock_status   = s2_q.mode;
    res_o.phase_average = s2_q.phase;
    res_o.drift_average = s2_q.drift;
  end

  assign res_valid_o = s2_valid_q;

  `ASSERT_CLK(s2_hold_a, (s2_valid_q && !en) |=> (s2_valid_q && $stable(s2_q)), "stalled result changed")
  `ASSERT_CLK(clear_a, (en && s1_valid_q && s1_q.clear) |=> (drift_acc_q == 32'sd0 && mode_q == pdlt_pkg::MODE_UNLOCKED && gc_q == 4'd0), "clear not applied")

endmodule

`default_nettype wire

FILE: sv/phase_detector_lock_tracker.sv
// Link phase tracker with lock detection. Tock, packet, direct-sample and
// clear items enter through a queue-style port (push/full); packet and sample
// items each give one result (correction, lock status, phase and drift
// averages) on the result side (empty/pop), tock and clear items give none.
// One item is accepted per cycle while full is low; a result is ready once
// its item has passed the front queue, the back-end s1 and s2 stages (where
// the phase and drift averages are updated) and the output queue. The
// configuration port is always ready and must only be written while no item
// is in flight; an alpha_shift write outside 1..8 is ignored.
`timescale 1ns / 1ps
`default_nettype none

module phase_detector_lock_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        time_stamp_i,
  input  logic signed [31:0] offset_sample_i,
  input  logic               push,
  output logic               full,
  output logic signed [20:0] correction_o,
  output logic [1:0]         lock_status_o,
  output logic signed [31:0] phase_average_o,
  output logic signed [31:0] drift_average_o,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i
);

  pdlt_pkg::cfg_t    cfg_q;
  pdlt_pkg::cmd_t    cmd;
  pdlt_pkg::result_t res, res_head;
  logic              cmd_valid, cmd_pop, res_valid, res_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha      <= pdlt_pkg::AlphaReset;
      cfg_q.lock_thr   <= pdlt_pkg::LockThrReset;
      cfg_q.unlock_thr <= pdlt_pkg::UnlockThrReset;
      cfg_q.max_corr   <= pdlt_pkg::MaxCorrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pdlt_pkg::cfg_idx_e'(cfg_index_i))
        pdlt_pkg::CFG_ALPHA: begin
          if (cfg_data_i >= pdlt_pkg::AlphaMin && cfg_data_i <= pdlt_pkg::AlphaMax) begin
            cfg_q.alpha <= cfg_data_i[3:0];
          end
        end
        pdlt_pkg::CFG_LOCK_THR:   cfg_q.lock_thr   <= cfg_data_i;
        pdlt_pkg::CFG_UNLOCK_THR: cfg_q.unlock_thr <= cfg_data_i;
        pdlt_pkg::CFG_MAX_CORR:   cfg_q.max_corr   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pdlt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .time_stamp_i   (time_stamp_i),
    .offset_sample_i(offset_sample_i),
    .push_i         (push),
    .full_o         (full),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  pdlt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_full_i (res_full)
  );

  pdlt_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_head)
  );

  assign correction_o    = res_head.correction;
  assign lock_status_o   = res_head.lock_status;
  assign phase_average_o = res_head.phase_average;
  assign drift_average_o = res_head.drift_average;

endmodule

`default_nettype wire
